@@ rtl/hvd_pkg.sv @@
// Shared types and constants of the haversine distance pipeline.
// Fixed field widths, fixed-point scalings, CORDIC arctangent table.
// No dependencies.
package hvd_pkg;

   // Field widths
   localparam int LAT_W      = 30;
   localparam int LON_W      = 31;
   localparam int DIST_W     = 25;
   localparam int CSR_DATA_W = 31;

   // Angles are degrees * 2^ANGLE_FRAC_BITS; fixed with the field widths, which
   // keep every angle difference within one full turn for the single-step wrap
   localparam int ANGLE_FRAC_BITS = 22;

   // Internal widths
   localparam int ANGLE_W      = 32;   // angle in units of 2^-(F+1) degree
   localparam int TRIG_W       = 34;   // Q30 values with headroom
   localparam int MAG_W        = 31;   // magnitude of a Q30 trig value
   localparam int PROD_W       = 62;   // product of two magnitudes
   localparam int SUM_W        = 64;   // signed haversine sum
   localparam int A_W          = 61;   // clamped haversine term, Q60 in [0, 1]
   localparam int ROOT_W       = 31;   // Q30 root
   localparam int RES_W        = 62;   // partial root inside the square root
   localparam int SQRT_STEPS   = 31;   // one result bit per step
   localparam int RED_MAG_W    = 30;   // folded angle magnitude
   localparam int DEG_PROD_W   = 62;
   localparam int DEG_X_W      = 37;
   localparam int RECIP_SPLIT  = 19;
   localparam int RECIP_SHIFT  = 43;
   localparam int DIV_PP_W     = DEG_X_W + RECIP_SPLIT;
   localparam int DIV_SUM_W    = DIV_PP_W + RECIP_SPLIT;
   localparam int ANG_W        = 31;   // final Q30 arc angle
   localparam int DPROD_W      = 55;
   localparam int SCALE_W      = 24;
   localparam int MAX_ITERATIONS = 30;

   typedef logic signed [TRIG_W-1:0] trig_type;

   typedef enum logic [0:0] {
      CSR_GOAL_LATITUDE  = 1'b0,
      CSR_GOAL_LONGITUDE = 1'b1
   } csr_index_type;

   // Turn sizes in units of 2^-(F+1) degree; a half turn is 45 * 2^DEG_SHIFT
   localparam longint HALF_TURN    = longint'(180) <<< (ANGLE_FRAC_BITS + 1);
   localparam longint FULL_TURN    = 2 * HALF_TURN;
   localparam longint QUARTER_TURN = HALF_TURN / 2;
   localparam int     DEG_SHIFT    = ANGLE_FRAC_BITS + 3;

   localparam logic [31:0]           PI_Q30   = 32'd3373259426;
   localparam logic [DEG_PROD_W-1:0] HALF_RND = DEG_PROD_W'(HALF_TURN / 2);

   // floor(x / 45) = (x * DIV45_MULT) >> RECIP_SHIFT for x below 2^DEG_X_W
   localparam logic [37:0] DIV45_MULT =
      38'(((64'd1 << RECIP_SHIFT) + 64'd44) / 64'd45);
   localparam logic [RECIP_SPLIT-1:0] DIV45_HI = DIV45_MULT[37:19];
   localparam logic [RECIP_SPLIT-1:0] DIV45_LO = DIV45_MULT[18:0];

   localparam trig_type CORDIC_K_Q30 = 34'sd652032874;

   // round(atan(2^-i) * 2^30)
   localparam logic [30:0] ATAN_Q30 [MAX_ITERATIONS] = '{
      31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
      31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
      31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
      31'd262144,    31'd131072,    31'd65536,     31'd32768,
      31'd16384,     31'd8192,      31'd4096,      31'd2048,
      31'd1024,      31'd512,       31'd256,       31'd128,
      31'd64,        31'd32,        31'd16,        31'd8,
      31'd4,         31'd2
   };

   localparam logic [A_W-1:0]     ONE_Q60    = A_W'(1) << 60;
   localparam logic [SCALE_W-1:0] DIST_SCALE = 24'd13047808;   // 2 * 6371 * 1024
   localparam logic [DIST_W-1:0]  DIST_MAX   = 25'd20495450;

   // Magnitude of a Q30 trig value
   function automatic logic [MAG_W-1:0] trig_mag(trig_type v);
      trig_type a;
      a = (v < 0) ? -v : v;
      return a[MAG_W-1:0];
   endfunction

endpackage

@@ rtl/hvd_req_if.sv @@
// Query channel: one query point per transfer.
// Depends on hvd_pkg for the field widths.
interface hvd_req_if;
   import hvd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] point_latitude;
   logic signed [LON_W-1:0] point_longitude;

   modport source (output valid, point_latitude, point_longitude, input ready);
   modport sink   (input valid, point_latitude, point_longitude, output ready);
endinterface

@@ rtl/hvd_rsp_if.sv @@
// Result channel: one distance per transfer.
// Depends on hvd_pkg for the field width.
interface hvd_rsp_if;
   import hvd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

@@ rtl/haversine_distance.sv @@
// Great-circle distance from each query point to the configured goal on a
// 6371 km sphere, one query per cycle. The block is a single pipeline of
// 2*TRIG_ITERATIONS + 44 stages: four parallel sine/cosine CORDIC lanes, the
// haversine products, two 31-step square roots and a vectoring CORDIC for the
// arcsine, each iteration in its own stage. With the result taken every
// cycle, a new query is accepted every cycle. When a finished distance is
// not taken, the whole pipeline holds and ready drops. Write the goal
// registers only while no query is in flight.
// Depends on hvd_pkg, hvd_req_if, hvd_rsp_if, hvd_sincos, hvd_sqrt.
module haversine_distance #(
   parameter int TRIG_ITERATIONS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   hvd_req_if.sink                          req_if,
   hvd_rsp_if.source                        rsp_if,
   input  logic                             csr_write_enable,
   input  hvd_pkg::csr_index_type           csr_index,
   input  logic [hvd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import hvd_pkg::*;

   localparam int SC_LAT     = TRIG_ITERATIONS + 5;
   localparam int IDX_M5     = SC_LAT + 5;
   localparam int PIPE_DEPTH = 1 + SC_LAT + 5 + SQRT_STEPS + TRIG_ITERATIONS + 2;
   localparam int LAST       = PIPE_DEPTH - 1;

   logic advance;
   logic [PIPE_DEPTH-1:0] valid_ff;

   logic signed [LAT_W-1:0] goal_lat_ff;
   logic signed [LON_W-1:0] goal_lon_ff;

   logic signed [ANGLE_W-1:0] ang_dlat_ff;
   logic signed [ANGLE_W-1:0] ang_dlon_ff;
   logic signed [ANGLE_W-1:0] ang_plat_ff;
   logic signed [ANGLE_W-1:0] ang_glat_ff;

   trig_type s_lat;
   trig_type s_lon;
   trig_type c_p;
   trig_type c_g;

   logic [MAG_W-1:0]  s_lat_mag;
   logic [MAG_W-1:0]  s_lon_mag;
   logic [MAG_W-1:0]  c_p_mag;
   logic [MAG_W-1:0]  c_g_mag;
   logic [PROD_W-1:0] sq1_ff;
   logic [PROD_W-1:0] p1_ff;
   logic [PROD_W-1:0] p2_ff;
   logic              n1_ff;
   logic              n2_ff;
   logic [PROD_W-1:0] p1_rnd;
   logic [PROD_W-1:0] p2_rnd;
   logic [PROD_W-1:0] sq2_ff;
   trig_type          u1_ff;
   trig_type          u2_ff;
   logic [PROD_W-1:0] sq3_ff;
   logic signed [SUM_W-1:0] uu_ff;
   logic signed [SUM_W-1:0] a_sum;
   logic [A_W-1:0]    a_ff;
   logic [A_W-1:0]    root_a_ff;
   logic [A_W-1:0]    root_b_ff;
   logic [ROOT_W-1:0] r_root;
   logic [ROOT_W-1:0] q_root;

   trig_type vec_x_ff [TRIG_ITERATIONS-1];
   trig_type vec_y_ff [TRIG_ITERATIONS-1];
   trig_type vec_z_ff [TRIG_ITERATIONS];

   trig_type             arc;
   logic [ANG_W-1:0]     arc_pos;
   logic [DPROD_W-1:0]   dprod_ff;
   logic [DPROD_W-1:0]   dprod_rnd;
   logic [DIST_W-1:0]    dist_rnd;
   logic [DIST_W-1:0]    dist_ff;

   // Whole pipeline moves unless a finished distance waits
   assign advance      = !valid_ff[LAST] || rsp_if.ready;
   assign req_if.ready = advance;
   assign rsp_if.valid = valid_ff[LAST];
   assign rsp_if.distance = dist_ff;

   // Goal registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_lat_ff <= '0;
         goal_lon_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GOAL_LATITUDE: begin
               goal_lat_ff <= csr_write_data[LAT_W-1:0];
            end
            CSR_GOAL_LONGITUDE: begin
               goal_lon_ff <= csr_write_data[LON_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_if.valid};
      end
   end

   // Form the four angles: half differences and full latitudes
   always_ff @(posedge clock) begin
      if (advance) begin
         ang_dlat_ff <= ANGLE_W'(goal_lat_ff) - ANGLE_W'(req_if.point_latitude);
         ang_dlon_ff <= ANGLE_W'(goal_lon_ff) - ANGLE_W'(req_if.point_longitude);
         ang_plat_ff <= ANGLE_W'(req_if.point_latitude) <<< 1;
         ang_glat_ff <= ANGLE_W'(goal_lat_ff) <<< 1;
      end
   end

   hvd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_sc_dlat (
      .clock(clock), .advance(advance), .angle(ang_dlat_ff),
      .cos_out(), .sin_out(s_lat)
   );
   hvd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_sc_dlon (
      .clock(clock), .advance(advance), .angle(ang_dlon_ff),
      .cos_out(), .sin_out(s_lon)
   );
   hvd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_sc_plat (
      .clock(clock), .advance(advance), .angle(ang_plat_ff),
      .cos_out(c_p), .sin_out()
   );
   hvd_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_sc_glat (
      .clock(clock), .advance(advance), .angle(ang_glat_ff),
      .cos_out(c_g), .sin_out()
   );

   assign s_lat_mag = trig_mag(s_lat);
   assign s_lon_mag = trig_mag(s_lon);
   assign c_p_mag   = trig_mag(c_p);
   assign c_g_mag   = trig_mag(c_g);

   assign p1_rnd = (p1_ff + (PROD_W'(1) << 29)) >> 30;
   assign p2_rnd = (p2_ff + (PROD_W'(1) << 29)) >> 30;
   assign a_sum  = $signed({2'b00, sq3_ff}) + uu_ff;

   // Haversine term: sin^2(dlat/2) + sin(dlon/2)cos(lat_p) * sin(dlon/2)cos(lat_g)
   always_ff @(posedge clock) begin
      if (advance) begin
         sq1_ff <= PROD_W'(s_lat_mag) * PROD_W'(s_lat_mag);
         p1_ff  <= PROD_W'(s_lon_mag) * PROD_W'(c_p_mag);
         p2_ff  <= PROD_W'(s_lon_mag) * PROD_W'(c_g_mag);
         n1_ff  <= s_lon[TRIG_W-1] ^ c_p[TRIG_W-1];
         n2_ff  <= s_lon[TRIG_W-1] ^ c_g[TRIG_W-1];

         u1_ff  <= n1_ff ? -trig_type'(p1_rnd[TRIG_W-1:0]) : trig_type'(p1_rnd[TRIG_W-1:0]);
         u2_ff  <= n2_ff ? -trig_type'(p2_rnd[TRIG_W-1:0]) : trig_type'(p2_rnd[TRIG_W-1:0]);
         sq2_ff <= sq1_ff;

         uu_ff  <= SUM_W'(u1_ff) * SUM_W'(u2_ff);
         sq3_ff <= sq2_ff;

         // Clamp to [0, 1]
         if (a_sum < 0) begin
            a_ff <= '0;
         end else if (a_sum > $signed({3'b000, ONE_Q60})) begin
            a_ff <= ONE_Q60;
         end else begin
            a_ff <= a_sum[A_W-1:0];
         end

         root_a_ff <= a_ff;
         root_b_ff <= ONE_Q60 - a_ff;
      end
   end

   hvd_sqrt u_sqrt_a (
      .clock(clock), .advance(advance), .value(root_a_ff), .root(r_root)
   );
   hvd_sqrt u_sqrt_b (
      .clock(clock), .advance(advance), .value(root_b_ff), .root(q_root)
   );

   // Vectoring CORDIC: atan2(r, q) gives asin(r)
   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_vec
      localparam trig_type ATAN_I = trig_type'({3'b000, ATAN_Q30[i]});
      trig_type x_prev;
      trig_type y_prev;
      trig_type z_prev;

      if (i == 0) begin : g_first
         assign x_prev = trig_type'({3'b000, q_root});
         assign y_prev = trig_type'({3'b000, r_root});
         assign z_prev = '0;
      end else begin : g_next
         assign x_prev = vec_x_ff[i-1];
         assign y_prev = vec_y_ff[i-1];
         assign z_prev = vec_z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            vec_z_ff[i] <= (y_prev >= 0) ? z_prev + ATAN_I : z_prev - ATAN_I;
         end
      end

      if (i < TRIG_ITERATIONS - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (advance) begin
               if (y_prev >= 0) begin
                  vec_x_ff[i] <= x_prev + (y_prev >>> i);
                  vec_y_ff[i] <= y_prev - (x_prev >>> i);
               end else begin
                  vec_x_ff[i] <= x_prev - (y_prev >>> i);
                  vec_y_ff[i] <= y_prev + (x_prev >>> i);
               end
            end
         end
      end
   end

   // Scale the arc to 1/1024 km and saturate
   assign arc       = vec_z_ff[TRIG_ITERATIONS-1];
   assign arc_pos   = (arc < 0) ? '0 : arc[ANG_W-1:0];
   assign dprod_rnd = dprod_ff + (DPROD_W'(1) << 29);
   assign dist_rnd  = dprod_rnd[30 +: DIST_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         dprod_ff <= DPROD_W'(arc_pos) * DPROD_W'(DIST_SCALE);
         dist_ff  <= (dist_rnd > DIST_MAX) ? DIST_MAX : dist_rnd;
      end
   end

   // Checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> valid_ff[0])
      else $error("accepted query did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(valid_ff) && $stable(dist_ff)))
      else $error("pipeline moved during a stall");

   a_root_split: assert property (@(posedge clock) disable iff (reset)
      valid_ff[IDX_M5] |-> ((root_a_ff + root_b_ff) == ONE_Q60))
      else $error("root operands do not sum to one");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.distance <= DIST_MAX))
      else $error("distance above saturation bound");

endmodule

@@ rtl/hvd_sincos.sv @@
// Pipelined sine and cosine of one angle: wrap and fold, degree to radian
// scaling, rotation CORDIC. Depends on hvd_pkg.
module hvd_sincos #(
   parameter int TRIG_ITERATIONS = 24
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [hvd_pkg::ANGLE_W-1:0] angle,
   output hvd_pkg::trig_type                 cos_out,
   output hvd_pkg::trig_type                 sin_out
);
   import hvd_pkg::*;

   localparam int WRAP_W = ANGLE_W + 2;
   localparam logic signed [WRAP_W-1:0] HALF_S    = WRAP_W'(HALF_TURN);
   localparam logic signed [WRAP_W-1:0] FULL_S    = WRAP_W'(FULL_TURN);
   localparam logic signed [WRAP_W-1:0] QUARTER_S = WRAP_W'(QUARTER_TURN);

   logic signed [WRAP_W-1:0] wrap_u;
   logic signed [WRAP_W-1:0] fold_u;
   logic                     fold_flip;

   logic [RED_MAG_W-1:0]  red_mag_ff;
   logic                  red_zneg_ff;
   logic                  red_flip_ff;
   logic [DEG_PROD_W-1:0] mul_prod_ff;
   logic                  mul_zneg_ff;
   logic                  mul_flip_ff;
   logic [DIV_PP_W-1:0]   div_hi_ff;
   logic [DIV_PP_W-1:0]   div_lo_ff;
   logic                  div_zneg_ff;
   logic                  div_flip_ff;
   logic [DEG_X_W-1:0]    deg_x;
   logic [DIV_SUM_W-1:0]  div_sum;
   logic [30:0]           rad_mag;
   trig_type              z0_ff;
   logic                  z0_flip_ff;

   trig_type rot_x_ff    [TRIG_ITERATIONS];
   trig_type rot_y_ff    [TRIG_ITERATIONS];
   trig_type rot_z_ff    [TRIG_ITERATIONS-1];
   logic     rot_flip_ff [TRIG_ITERATIONS];
   trig_type cos_ff;
   trig_type sin_ff;

   // Wrap into one turn around zero, then fold into the right half plane
   always_comb begin
      wrap_u = WRAP_W'(angle);
      if (wrap_u >= HALF_S) begin
         wrap_u = wrap_u - FULL_S;
      end else if (wrap_u < -HALF_S) begin
         wrap_u = wrap_u + FULL_S;
      end
      fold_u    = wrap_u;
      fold_flip = 1'b0;
      if (wrap_u > QUARTER_S) begin
         fold_u    = wrap_u - HALF_S;
         fold_flip = 1'b1;
      end else if (wrap_u < -QUARTER_S) begin
         fold_u    = wrap_u + HALF_S;
         fold_flip = 1'b1;
      end
   end

   // Scale to radians: round(|u| * pi / half turn), divide by 45 via reciprocal
   assign deg_x   = mul_prod_ff[DEG_SHIFT +: DEG_X_W];
   assign div_sum = DIV_SUM_W'({div_hi_ff, {RECIP_SPLIT{1'b0}}}) + DIV_SUM_W'(div_lo_ff);
   assign rad_mag = div_sum[RECIP_SHIFT +: 31];

   always_ff @(posedge clock) begin
      if (advance) begin
         red_mag_ff  <= RED_MAG_W'((fold_u < 0) ? -fold_u : fold_u);
         red_zneg_ff <= fold_u < 0;
         red_flip_ff <= fold_flip;

         mul_prod_ff <= DEG_PROD_W'(red_mag_ff) * DEG_PROD_W'(PI_Q30) + HALF_RND;
         mul_zneg_ff <= red_zneg_ff;
         mul_flip_ff <= red_flip_ff;

         div_hi_ff   <= DIV_PP_W'(deg_x) * DIV_PP_W'(DIV45_HI);
         div_lo_ff   <= DIV_PP_W'(deg_x) * DIV_PP_W'(DIV45_LO);
         div_zneg_ff <= mul_zneg_ff;
         div_flip_ff <= mul_flip_ff;

         z0_ff      <= div_zneg_ff ? -trig_type'({3'b000, rad_mag})
                                   :  trig_type'({3'b000, rad_mag});
         z0_flip_ff <= div_flip_ff;
      end
   end

   // Rotation CORDIC, one iteration per stage
   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_rot
      localparam trig_type ATAN_I = trig_type'({3'b000, ATAN_Q30[i]});
      trig_type x_prev;
      trig_type y_prev;
      trig_type z_prev;
      logic     flip_prev;

      if (i == 0) begin : g_first
         assign x_prev    = CORDIC_K_Q30;
         assign y_prev    = '0;
         assign z_prev    = z0_ff;
         assign flip_prev = z0_flip_ff;
      end else begin : g_next
         assign x_prev    = rot_x_ff[i-1];
         assign y_prev    = rot_y_ff[i-1];
         assign z_prev    = rot_z_ff[i-1];
         assign flip_prev = rot_flip_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (z_prev >= 0) begin
               rot_x_ff[i] <= x_prev - (y_prev >>> i);
               rot_y_ff[i] <= y_prev + (x_prev >>> i);
            end else begin
               rot_x_ff[i] <= x_prev + (y_prev >>> i);
               rot_y_ff[i] <= y_prev - (x_prev >>> i);
            end
            rot_flip_ff[i] <= flip_prev;
         end
      end

      if (i < TRIG_ITERATIONS - 1) begin : g_angle
         always_ff @(posedge clock) begin
            if (advance) begin
               rot_z_ff[i] <= (z_prev >= 0) ? z_prev - ATAN_I : z_prev + ATAN_I;
            end
         end
      end
   end

   // Undo the fold: a half-turn shift negates both
   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= rot_flip_ff[TRIG_ITERATIONS-1] ? -rot_x_ff[TRIG_ITERATIONS-1]
                                                  :  rot_x_ff[TRIG_ITERATIONS-1];
         sin_ff <= rot_flip_ff[TRIG_ITERATIONS-1] ? -rot_y_ff[TRIG_ITERATIONS-1]
                                                  :  rot_y_ff[TRIG_ITERATIONS-1];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ rtl/hvd_sqrt.sv @@
// Pipelined floor square root of a Q60 value, one result bit per stage.
// Depends on hvd_pkg.
module hvd_sqrt (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [hvd_pkg::A_W-1:0]      value,
   output logic [hvd_pkg::ROOT_W-1:0]   root
);
   import hvd_pkg::*;

   logic [A_W-1:0]   rem_ff [SQRT_STEPS-1];
   logic [RES_W-1:0] res_ff [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam int               K   = SQRT_STEPS - 1 - j;
      localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * K);
      logic [A_W-1:0]   rem_prev;
      logic [RES_W-1:0] res_prev;
      logic [RES_W:0]   trial;
      logic             fits;

      if (j == 0) begin : g_first
         assign rem_prev = value;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      assign trial = {1'b0, res_prev} + {1'b0, BIT};
      assign fits  = {2'b00, rem_prev} >= trial;

      always_ff @(posedge clock) begin
         if (advance) begin
            res_ff[j] <= fits ? (res_prev >> 1) + BIT : res_prev >> 1;
         end
      end

      if (j < SQRT_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= fits ? rem_prev - trial[A_W-1:0] : rem_prev;
            end
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule
